FILE: rtl/core/alle_pkg.sv
`timescale 1ns / 1ps

package alle_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int VALUE_W      = 32;
    // Wide enough for a position or a fill count at any capacity up to 127.
    localparam int POS_W        = 7;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_EMPTY     = 2'd3;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_ROTATE,
        CM_LOAD,
        CM_PACK
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t                 mode;
        logic [POS_W-1:0]           pos;
        logic signed [VALUE_W-1:0]  data;
        logic                       drop;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/alle_cell.sv
`timescale 1ns / 1ps

module alle_cell
    import alle_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cell_ctrl_t                ctrl,
    input  logic                      nb_valid,
    input  logic signed [VALUE_W-1:0] nb_value,
    output logic                      out_valid,
    output logic signed [VALUE_W-1:0] out_value
);

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        case (ctrl.mode)
            CM_ROTATE: begin
                valid_next = nb_valid;
                value_next = nb_value;
            end
            CM_LOAD: begin
                if (ctrl.pos == POS_W'(INDEX)) begin
                    valid_next = 1'b1;
                    value_next = ctrl.data;
                end
            end
            CM_PACK: begin
                if (POS_W'(INDEX) >= ctrl.pos) begin
                    valid_next = nb_valid;
                    value_next = nb_value;
                end
            end
            default: begin
                valid_next = valid_reg;
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;

endmodule

FILE: rtl/core/alle_chain.sv
`timescale 1ns / 1ps

module alle_chain
    import alle_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cell_ctrl_t                ctrl,
    output logic                      head_valid,
    output logic signed [VALUE_W-1:0] head_value
);

    logic                      cell_valid [CAPACITY];
    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic                      tail_valid;

    // The head item wraps to the tail on a rotation unless it is being deleted.
    assign tail_valid = (ctrl.mode == CM_ROTATE) && !ctrl.drop && cell_valid[0];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                      nb_valid;
        logic signed [VALUE_W-1:0] nb_value;

        if (i == CAPACITY - 1) begin : g_tail
            assign nb_valid = tail_valid;
            assign nb_value = cell_value[0];
        end else begin : g_body
            assign nb_valid = cell_valid[i+1];
            assign nb_value = cell_value[i+1];
        end

        alle_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .nb_valid  (nb_valid),
            .nb_value  (nb_value),
            .out_valid (cell_valid[i]),
            .out_value (cell_value[i])
        );
    end

    assign head_valid = cell_valid[0];
    assign head_value = cell_value[0];

endmodule

FILE: rtl/core/array_linked_list_engine.sv
`timescale 1ns / 1ps
// Insert, unknown ops and an empty dump: result registered from ST_RESP once the output is free.
// Delete: a rotation over every cell of the chain, a pack step if found, then the result.
// Dump: one result per stored value; each rotation step waits while the output stalls.
// One item is in work at a time; the next is accepted once its results are in the output register.
// Synchronous active-low reset empties the list by clearing every cell's valid flag.

module array_linked_list_engine
    import alle_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_op,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic signed [VALUE_W-1:0] m_item_value,
    output logic                      m_item_valid,
    output logic                      m_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_LAST = CNT_W'(CAPACITY - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEL_SCAN,
        ST_DEL_PACK,
        ST_DUMP,
        ST_RESP
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          step_reg, step_next;
    logic [CNT_W-1:0]          hole_reg, hole_next;
    logic                      found_reg, found_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic [1:0]                resp_reg, resp_next;
    logic                      m_valid_reg, m_valid_next;
    logic [1:0]                m_status_reg, m_status_next;
    logic signed [VALUE_W-1:0] m_value_reg, m_value_next;
    logic                      m_ivalid_reg, m_ivalid_next;
    logic                      m_last_reg, m_last_next;

    cell_ctrl_t                ctrl;
    logic                      head_valid;
    logic signed [VALUE_W-1:0] head_value;
    logic                      out_free;
    logic                      accept;
    logic                      match;

    alle_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .head_valid (head_valid),
        .head_value (head_value)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign match    = head_valid && (head_value == key_reg) && !found_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        hole_next     = hole_reg;
        found_next    = found_reg;
        key_next      = key_reg;
        resp_next     = resp_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_ivalid_next = m_ivalid_reg;
        m_last_next   = m_last_reg;
        ctrl.mode     = CM_HOLD;
        ctrl.pos      = POS_W'(count_reg);
        ctrl.data     = s_value;
        ctrl.drop     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_op)
                        OP_INSERT: begin
                            if (count_reg == CAP_FULL) begin
                                resp_next = STATUS_FULL;
                            end else begin
                                ctrl.mode  = CM_LOAD;
                                count_next = count_reg + 1'b1;
                                resp_next  = STATUS_OK;
                            end
                            state_next = ST_RESP;
                        end
                        OP_DELETE: begin
                            key_next   = s_value;
                            step_next  = '0;
                            found_next = 1'b0;
                            state_next = ST_DEL_SCAN;
                        end
                        OP_DUMP: begin
                            if (count_reg == '0) begin
                                resp_next  = STATUS_EMPTY;
                                state_next = ST_RESP;
                            end else begin
                                step_next  = '0;
                                state_next = ST_DUMP;
                            end
                        end
                        default: begin
                            resp_next  = STATUS_OK;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_DEL_SCAN: begin
                ctrl.mode = CM_ROTATE;
                ctrl.drop = match;
                if (match) begin
                    found_next = 1'b1;
                    hole_next  = step_reg;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == CAP_LAST) begin
                    if (found_reg || match) begin
                        state_next = ST_DEL_PACK;
                    end else begin
                        resp_next  = STATUS_NOT_FOUND;
                        state_next = ST_RESP;
                    end
                end
            end
            ST_DEL_PACK: begin
                ctrl.mode  = CM_PACK;
                ctrl.pos   = POS_W'(hole_reg);
                count_next = count_reg - 1'b1;
                resp_next  = STATUS_OK;
                state_next = ST_RESP;
            end
            ST_DUMP: begin
                if (out_free) begin
                    ctrl.mode = CM_ROTATE;
                    if (head_valid) begin
                        m_valid_next  = 1'b1;
                        m_status_next = STATUS_OK;
                        m_value_next  = head_value;
                        m_ivalid_next = 1'b1;
                        m_last_next   = (step_reg == count_reg - 1'b1);
                    end
                    step_next = step_reg + 1'b1;
                    if (step_reg == CAP_LAST) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = resp_reg;
                    m_value_next  = '0;
                    m_ivalid_next = 1'b0;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        hole_reg     <= hole_next;
        key_reg      <= key_next;
        resp_reg     <= resp_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_ivalid_reg <= m_ivalid_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_item_value = m_value_reg;
    assign m_item_valid = m_ivalid_reg;
    assign m_last       = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_FULL)
        else $error("Fill count exceeds capacity.");

    a_head_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && count_reg != '0) |-> head_valid)
        else $error("Non-empty list has no item in the head cell.");

    a_found_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEL_SCAN && found_reg) |-> (count_reg != '0))
        else $error("Match found in an empty list.");

    a_full_insert_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == OP_INSERT && count_reg == CAP_FULL) |=> $stable(count_reg))
        else $error("Insert into a full list changed the fill count.");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import alle_pkg::*;

    localparam int CAP = DEF_CAPACITY;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int SEGMENT_LEN = 60;

    typedef struct {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;
    } request_t;

    typedef struct {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] value;
        logic                      item_valid;
        logic                      last;
    } list_result_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_op = OP_INSERT;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [1:0]                m_status;
    logic signed [VALUE_W-1:0] m_item_value;
    logic                      m_item_valid;
    logic                      m_last;

    request_t                  pending_requests[$];
    list_result_t              expected_results[$];
    logic signed [VALUE_W-1:0] stored_values[$];
    logic signed [VALUE_W-1:0] inserted_history[$];

    int  sender_idle_pct = 31;
    int  receiver_idle_pct = 68;
    bit  hold_trigger = 1'b0;
    bit  hold_taken = 1'b0;
    int  hold_left = 0;
    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  accepted_count = 0;
    int  checked_count = 0;
    int  dump_count = 0;
    int  full_count = 0;
    int  not_found_count = 0;
    bit  growing = 1'b1;
    int  segment_left = SEGMENT_LEN;

    array_linked_list_engine dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_item_value (m_item_value),
        .m_item_valid (m_item_valid),
        .m_last       (m_last)
    );

    always #5 aclk = ~aclk;

    task automatic predict_list_results(input logic [1:0] op,
                                        input logic signed [VALUE_W-1:0] value);
        list_result_t r;
        int           idx;
        r = '{STATUS_OK, '0, 1'b0, 1'b1};
        idx = -1;
        case (op)
            OP_INSERT: begin
                if (stored_values.size() >= CAP) begin
                    r.status = STATUS_FULL;
                    full_count++;
                end else begin
                    stored_values.push_back(value);
                end
            end
            OP_DELETE: begin
                for (int i = 0; i < stored_values.size(); i++) begin
                    if (stored_values[i] == value) begin
                        idx = i;
                        break;
                    end
                end
                if (idx < 0) begin
                    r.status = STATUS_NOT_FOUND;
                    not_found_count++;
                end else begin
                    stored_values.delete(idx);
                end
            end
            OP_DUMP: begin
                dump_count++;
                if (stored_values.size() == 0) begin
                    r.status = STATUS_EMPTY;
                end
            end
            default: ;
        endcase
        if (op == OP_DUMP && stored_values.size() != 0) begin
            foreach (stored_values[i]) begin
                r.value      = stored_values[i];
                r.item_valid = 1'b1;
                r.last       = (i == stored_values.size() - 1);
                expected_results.push_back(r);
            end
        end else begin
            expected_results.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("testbench: mismatch on result %0d, %s: got %h, expected %h",
                 checked_count, what, got, want);
    endtask

    task automatic add_request(input logic [1:0] op, input logic [VALUE_W-1:0] value);
        request_t q;
        q.op = op;
        q.value = value;
        pending_requests.push_back(q);
        if (op == OP_INSERT) begin
            inserted_history.push_back(value);
            if (inserted_history.size() > 48) begin
                void'(inserted_history.pop_front());
            end
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(99) < 60) begin
            return VALUE_W'($urandom_range(15)) - VALUE_W'(8);
        end
        return $urandom;
    endfunction

    task automatic add_random_requests(input int count);
        int roll;
        for (int n = 0; n < count; n++) begin
            if (segment_left == 0) begin
                growing = !growing;
                segment_left = SEGMENT_LEN;
            end
            segment_left--;
            roll = $urandom_range(99);
            if (roll < (growing ? 85 : 10)) begin
                add_request(OP_INSERT, pick_value());
            end else if (roll < 90) begin
                if (inserted_history.size() != 0 && $urandom_range(99) < 70) begin
                    add_request(OP_DELETE,
                                inserted_history[$urandom_range(inserted_history.size() - 1)]);
                end else begin
                    add_request(OP_DELETE, pick_value());
                end
            end else if (roll < 98) begin
                add_request(OP_DUMP, $urandom);
            end else begin
                add_request(OP_UNUSED, $urandom);
            end
        end
    endtask

    task automatic drain_requests();
        while (pending_requests.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        request_t q;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_list_results(s_op, s_value);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    q = pending_requests.pop_front();
                    s_op    <= q.op;
                    s_value <= q.value;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_trigger && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        list_result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("no result expected", m_item_value, '0);
            end else begin
                w = expected_results.pop_front();
                if (m_status !== w.status) begin
                    report_mismatch("status", 32'(m_status), 32'(w.status));
                end
                if (m_item_value !== w.value) begin
                    report_mismatch("item_value", m_item_value, w.value);
                end
                if (m_item_valid !== w.item_valid) begin
                    report_mismatch("item_valid", 32'(m_item_valid), 32'(w.item_valid));
                end
                if (m_last !== w.last) begin
                    report_mismatch("last", 32'(m_last), 32'(w.last));
                end
            end
            checked_count++;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        add_request(OP_DUMP, '0);
        add_request(OP_DELETE, 32'd5);
        add_request(OP_UNUSED, '0);
        add_request(OP_INSERT, 32'h8000_0000);
        add_request(OP_INSERT, 32'h7FFF_FFFF);
        add_request(OP_INSERT, 32'h0000_0000);
        add_request(OP_INSERT, 32'hFFFF_FFFF);
        add_request(OP_INSERT, 32'h7FFF_FFFF);
        add_request(OP_DUMP, '0);
        add_request(OP_DELETE, 32'h7FFF_FFFF);
        add_request(OP_DELETE, 32'd12345);
        add_request(OP_DELETE, 32'h8000_0000);
        add_request(OP_DELETE, 32'hFFFF_FFFF);
        add_request(OP_DUMP, '0);
        add_request(OP_INSERT, 32'hA5A5_A5A5);
        add_request(OP_INSERT, 32'h5A5A_5A5A);
        add_request(OP_UNUSED, 32'hFFFF_FFFF);
        add_request(OP_DUMP, 32'hDEAD_BEEF);
        add_request(OP_DELETE, 32'h0000_0000);
        add_request(OP_DELETE, 32'h7FFF_FFFF);
        add_request(OP_DELETE, 32'hA5A5_A5A5);
        add_request(OP_DELETE, 32'h5A5A_5A5A);
        add_request(OP_DUMP, '0);
        add_random_requests(130);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        drain_requests();

        sender_idle_pct = 68;
        receiver_idle_pct = 31;
        add_random_requests(150);
        drain_requests();

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        hold_trigger = 1'b1;
        add_random_requests(150);
        drain_requests();

        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4 * CAP) @(posedge aclk);

        $display("testbench: %0d items accepted, %0d results checked, %0d dumps",
                 accepted_count, checked_count, dump_count);
        $display("testbench: %0d inserts refused as full, %0d deletes not found",
                 full_count, not_found_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
